// File: src/sida_pkg.sv
// Shared types and constants for the shifting insert/delete array.
package sida_pkg;

    // Fixed field widths of the request and result items.
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int ERR_W    = 2;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // Default sizing of the array.
    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Request kinds.
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_READ   = 3'd2,
        OP_WRITE  = 3'd3,
        OP_APPEND = 3'd4
    } t_op;

    // Result error codes.
    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_RANGE = 2'd1,
        ERR_FULL  = 2'd2
    } t_err;

    // Commands broadcast to every cell of the chain.
    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic write_at;
    } t_cell_ctl;

endpackage

// File: src/sida_cell.sv
// One storage cell of the shifting array chain.
module sida_cell #(
    parameter int INDEX      = 0,
    parameter int DATA_WIDTH = sida_pkg::DATA_WIDTH_DEF,
    parameter int PW         = sida_pkg::POS_W
) (
    input  logic                  i_clk,
    input  sida_pkg::t_cell_ctl   i_ctl,
    input  logic [PW-1:0]         i_pos,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_prev,
    input  logic [DATA_WIDTH-1:0] i_next,
    output logic [DATA_WIDTH-1:0] o_data
);

    localparam logic [PW-1:0] IDX = PW'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    // An insert opens a gap at the position, a delete closes it, a write replaces in place.
    always_comb begin
        n_data = r_data;
        if (i_ctl.shift_up) begin
            if (IDX > i_pos) begin
                n_data = i_prev;
            end else if (IDX == i_pos) begin
                n_data = i_value;
            end
        end else if (i_ctl.shift_down) begin
            if (IDX >= i_pos) begin
                n_data = i_next;
            end
        end else if (i_ctl.write_at) begin
            if (IDX == i_pos) begin
                n_data = i_value;
            end
        end
    end

    // Element storage needs no reset.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// File: src/shifting_insert_delete_array.sv
// Top level of the shifting insert/delete array: decode, count, cell chain, result register.
//
//  Channel   Direction  tdata (low bit up)             tuser
//  s_axis    request    position[4:0], value[36:5]     op[2:0]
//  m_axis    result     read_value[31:0], count[36:32] error[1:0]
//
// Every request finishes at the clock edge that accepts it: all cells shift in parallel at that edge,
// and its result sits in the output register from the next cycle.
// One request per cycle is sustained while results are taken.
// Reset clears the element count and the output valid; element storage is not cleared.
// A stalled result holds the output register and blocks new requests until it is taken.
module shifting_insert_delete_array #(
    parameter int CAPACITY   = sida_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = sida_pkg::DATA_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // position[4:0], value[36:5], zeros above
    input  logic [sida_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // op[2:0]
    input  logic [sida_pkg::OP_W-1:0]          i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // read_value[31:0], count[36:32], zeros above
    output logic [sida_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // error[1:0]
    output logic [sida_pkg::ERR_W-1:0]         o_m_axis_tuser
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int PW    = (CW > sida_pkg::POS_W) ? CW : sida_pkg::POS_W;
    localparam int NREAD = (CAPACITY < 32) ? CAPACITY : 32;
    localparam int VW    = sida_pkg::VALUE_W;

    logic                       acc;
    sida_pkg::t_op              req_op;
    logic [sida_pkg::POS_W-1:0] req_pos;
    logic [VW-1:0]              req_value;
    logic [DATA_WIDTH-1:0]      store_value;
    logic [PW-1:0]              pos_c;
    logic [PW-1:0]              cnt_c;
    logic                       full;

    logic [CW-1:0]              r_count;
    logic [CW-1:0]              n_count;
    sida_pkg::t_err             n_err;
    logic [VW-1:0]              n_rd;
    sida_pkg::t_cell_ctl        ctl;
    logic [PW-1:0]              cell_pos;
    logic [DATA_WIDTH-1:0]      sel_data;
    logic [VW-1:0]              sel_value;

    logic                       r_out_valid;
    logic [VW-1:0]              r_rd;
    logic [sida_pkg::COUNT_W-1:0] r_cnt;
    sida_pkg::t_err             r_err;

    logic [DATA_WIDTH-1:0]      cell_data [CAPACITY];

    // Request unpacking.
    assign req_op    = sida_pkg::t_op'(i_s_axis_tuser);
    assign req_pos   = i_s_axis_tdata[sida_pkg::POS_W-1:0];
    assign req_value = i_s_axis_tdata[sida_pkg::POS_W +: VW];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign acc             = i_s_axis_tvalid && o_s_axis_tready;

    // Fit the request value to the element width.
    generate
        if (DATA_WIDTH <= VW) begin : g_val_narrow
            assign store_value = req_value[DATA_WIDTH-1:0];
        end else begin : g_val_wide
            assign store_value = DATA_WIDTH'(req_value);
        end
    endgenerate

    assign pos_c = PW'(req_pos);
    assign cnt_c = PW'(r_count);
    assign full  = (r_count == CW'(CAPACITY));

    // Read selection over the cells a position can reach.
    always_comb begin
        sel_data = '0;
        for (int k = 0; k < NREAD; k++) begin
            if (req_pos == sida_pkg::POS_W'(k)) begin
                sel_data = cell_data[k];
            end
        end
    end

    // Fit the selected element to the result value width.
    generate
        if (DATA_WIDTH <= VW) begin : g_rd_narrow
            assign sel_value = VW'(sel_data);
        end else begin : g_rd_wide
            assign sel_value = sel_data[VW-1:0];
        end
    endgenerate

    // Request decode: bounds checks, cell commands and the next count.
    always_comb begin
        ctl      = '0;
        cell_pos = pos_c;
        n_count  = r_count;
        n_err    = sida_pkg::ERR_OK;
        n_rd     = '0;
        unique case (req_op)
            sida_pkg::OP_INSERT: begin
                if (pos_c > cnt_c) begin
                    n_err = sida_pkg::ERR_RANGE;
                end else if (full) begin
                    n_err = sida_pkg::ERR_FULL;
                end else begin
                    ctl.shift_up = 1'b1;
                    n_count      = r_count + CW'(1);
                end
            end
            sida_pkg::OP_APPEND: begin
                cell_pos = cnt_c;
                if (full) begin
                    n_err = sida_pkg::ERR_FULL;
                end else begin
                    ctl.shift_up = 1'b1;
                    n_count      = r_count + CW'(1);
                end
            end
            sida_pkg::OP_DELETE: begin
                if (pos_c >= cnt_c) begin
                    n_err = sida_pkg::ERR_RANGE;
                end else begin
                    ctl.shift_down = 1'b1;
                    n_count        = r_count - CW'(1);
                end
            end
            sida_pkg::OP_READ: begin
                if (pos_c >= cnt_c) begin
                    n_err = sida_pkg::ERR_RANGE;
                end else begin
                    n_rd = sel_value;
                end
            end
            sida_pkg::OP_WRITE: begin
                if (pos_c >= cnt_c) begin
                    n_err = sida_pkg::ERR_RANGE;
                end else begin
                    ctl.write_at = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (!acc) begin
            ctl = '0;
        end
    end

    // Chain of cells, each taking data from its neighbors.
    generate
        for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
            logic [DATA_WIDTH-1:0] prev_data;
            logic [DATA_WIDTH-1:0] next_data;
            if (g == 0) begin : g_first
                assign prev_data = '0;
            end else begin : g_mid_prev
                assign prev_data = cell_data[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign next_data = '0;
            end else begin : g_mid_next
                assign next_data = cell_data[g+1];
            end
            sida_cell #(
                .INDEX      (g),
                .DATA_WIDTH (DATA_WIDTH),
                .PW         (PW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (ctl),
                .i_pos   (cell_pos),
                .i_value (store_value),
                .i_prev  (prev_data),
                .i_next  (next_data),
                .o_data  (cell_data[g])
            );
        end
    endgenerate

    // Element count and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; the count field keeps only its low bits.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd  <= n_rd;
            r_cnt <= sida_pkg::COUNT_W'(n_count);
            r_err <= n_err;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = sida_pkg::OUT_TDATA_W'({r_cnt, r_rd});
    assign o_m_axis_tuser  = r_err;

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count above capacity");

    // A successful insert or append grows the count by one.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && ctl.shift_up) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the count");

    // A full error is only raised on a full array.
    a_full_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && n_err == sida_pkg::ERR_FULL) |-> full)
        else $error("full error on an array with room");

    // A successful delete shrinks the count by one.
    a_delete_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && ctl.shift_down) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("delete did not shrink the count");

endmodule
